// File: hdl/motor_holding_brake_control_unit_assert.svh
// ----------------------------------------------------------------------------
// Holding-brake control: assertion macros
// Shorthand for the clocked, reset-qualified checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MOTOR_HOLDING_BRAKE_CONTROL_UNIT_ASSERT_SVH
`define MOTOR_HOLDING_BRAKE_CONTROL_UNIT_ASSERT_SVH

// Same-cycle implication
`define MHB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MHB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mhb_pkg.sv
// ----------------------------------------------------------------------------
// Holding-brake control package
// Widths, register codes, shared types and the saturating absolute value.
// ----------------------------------------------------------------------------
package mhb_pkg;

   // Delay counter width
   localparam int DelayBits   = 16;
   localparam int CfgDataBits = 16;
   localparam int VelBits     = 32;
   localparam int AbsBits     = VelBits - 1;

   // Low-speed threshold is the setting times this scale
   localparam int unsigned SpeedScale = 2200;
   localparam int ThreshBits =
      $clog2(((2 ** CfgDataBits) - 1) * SpeedScale + 1);

   // Register indexes
   localparam int CsrIndexBits = 2;
   typedef logic [CsrIndexBits-1:0] csr_index_type;
   localparam csr_index_type RegReleaseDelay = csr_index_type'(0);
   localparam csr_index_type RegEngageDelay  = csr_index_type'(1);
   localparam csr_index_type RegStopSpeed    = csr_index_type'(2);

   typedef logic [CfgDataBits-1:0]    cfg_data_type;
   typedef logic signed [VelBits-1:0] vel_type;
   typedef logic [AbsBits-1:0]        abs_type;
   typedef logic [ThreshBits-1:0]     thresh_type;
   typedef logic [DelayBits-1:0]      delay_type;
   typedef logic [1:0]                lsc_type;

   // Consecutive low-speed ticks that engage the brake
   localparam lsc_type LowSpeedTicks = lsc_type'(3);

   // Settings as seen by the step logic
   typedef struct packed {
      cfg_data_type release_delay;
      cfg_data_type engage_delay;
      thresh_type   speed_thresh;
   } cfg_type;

   // One registered tick
   typedef struct packed {
      logic    run_command;
      logic    drive_ready;
      abs_type abs_filtered;
      abs_type abs_feedback;
   } tick_type;

   // Brake state seen outside the step logic
   typedef struct packed {
      logic    brake_open;
      lsc_type low_speed_count;
   } status_type;

   // Absolute value; the most negative input saturates to the largest positive
   function automatic abs_type sat_abs(input vel_type v);
      logic [VelBits-1:0] neg;
      neg = ~v + 1'b1;
      if (!v[VelBits-1]) begin
         return v[AbsBits-1:0];
      end else if (v[AbsBits-1:0] == '0) begin
         return '1;
      end else begin
         return neg[AbsBits-1:0];
      end
   endfunction

endpackage

// File: hdl/mhb_if.sv
// ----------------------------------------------------------------------------
// Holding-brake control channels
// Tick, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mhb_req_if;
   import mhb_pkg::*;
   logic    valid;
   logic    ready;
   logic    run_command;
   logic    drive_ready;
   vel_type speed_filtered;
   vel_type speed_feedback;
   modport source (output valid, output run_command, output drive_ready,
                   output speed_filtered, output speed_feedback, input ready);
   modport sink   (input valid, input run_command, input drive_ready,
                   input speed_filtered, input speed_feedback, output ready);
endinterface

interface mhb_rsp_if;
   logic valid;
   logic ready;
   logic brake_released;
   modport source (output valid, output brake_released, input ready);
   modport sink   (input valid, input brake_released, output ready);
endinterface

interface mhb_csr_if;
   import mhb_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/motor_holding_brake_control_unit.sv
// ----------------------------------------------------------------------------
// Motor holding-brake control unit
// Input register, step logic and result handshake for the holding brake.
// ----------------------------------------------------------------------------
// Takes one control tick per clock cycle. A tick is captured in the input
// register (absolute velocities formed on the way in); when it moves on, the
// step logic registers the new brake state and counters, and that brake state
// is presented as the result item. Throughput is one tick per cycle while
// results are taken;
// a stalled result holds the step logic and, once the input register is full,
// the input channel. Settings are written through the register channel,
// which is always ready; the low-speed setting is scaled by 2200 on write.
`include "motor_holding_brake_control_unit_assert.svh"

module motor_holding_brake_control_unit (
   input  logic       clock,
   input  logic       reset,
   mhb_req_if.sink    req_if,
   mhb_rsp_if.source  rsp_if,
   mhb_csr_if.sink    csr_if
);
   import mhb_pkg::*;

   cfg_type    cfg;
   status_type status;
   tick_type   tick_ff, tick_in;
   logic       in_valid_ff, in_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       advance;
   logic       brake_open;
   logic       stop_shut;
   logic       run_open;
   logic       lsc_at_limit;

   mhb_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // Move the held item on when the result slot is free or being emptied
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready   = !in_valid_ff || advance;
   assign req_take       = req_if.valid && req_if.ready;

   // Capture the tick with absolute velocities
   assign tick_in.run_command  = req_if.run_command;
   assign tick_in.drive_ready  = req_if.drive_ready;
   assign tick_in.abs_filtered = sat_abs(req_if.speed_filtered);
   assign tick_in.abs_feedback = sat_abs(req_if.speed_feedback);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload until the next item arrives
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff <= tick_in;
      end
   end

   mhb_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (tick_ff),
      .cfg     (cfg),
      .status  (status)
   );

   // Brake state after the last tick is the result
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.brake_released = status.brake_open;

   // Checks
   assign brake_open   = status.brake_open;
   assign stop_shut    = advance && !tick_ff.run_command && !status.brake_open;
   assign run_open     = advance && tick_ff.run_command && status.brake_open;
   assign lsc_at_limit = status.low_speed_count == LowSpeedTicks;

   `MHB_ASSERT_NXT(a_result_loaded, clock, reset, advance, rsp_valid_ff, "result not loaded")
   `MHB_ASSERT_NXT(a_stop_never_opens, clock, reset, stop_shut, !brake_open, "opened on stop")
   `MHB_ASSERT_NXT(a_run_never_closes, clock, reset, run_open, brake_open, "engaged on run")
   `MHB_ASSERT_IMP(a_lsc_bound, clock, reset, 1'b1, !lsc_at_limit, "low-speed count at limit")

endmodule

// File: hdl/mhb_csr.sv
// ----------------------------------------------------------------------------
// Holding-brake control registers
// Holds the delay settings and the pre-scaled low-speed threshold.
// ----------------------------------------------------------------------------
module mhb_csr (
   input  logic             clock,
   input  logic             reset,
   mhb_csr_if.sink          csr_if,
   output mhb_pkg::cfg_type cfg
);
   import mhb_pkg::*;

   cfg_data_type release_ff, release_in;
   cfg_data_type engage_ff, engage_in;
   thresh_type   thresh_ff, thresh_in;
   logic         wr_en;

   // Writes are always taken
   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;

   // Decode the write; scale the speed setting once here
   always_comb begin
      release_in = release_ff;
      engage_in  = engage_ff;
      thresh_in  = thresh_ff;
      if (wr_en) begin
         unique case (csr_if.index)
            RegReleaseDelay: release_in = csr_if.data;
            RegEngageDelay:  engage_in  = csr_if.data;
            RegStopSpeed:    thresh_in  = ThreshBits'(csr_if.data * SpeedScale);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_ff <= '0;
         engage_ff  <= '0;
         thresh_ff  <= '0;
      end else begin
         release_ff <= release_in;
         engage_ff  <= engage_in;
         thresh_ff  <= thresh_in;
      end
   end

   assign cfg.release_delay = release_ff;
   assign cfg.engage_delay  = engage_ff;
   assign cfg.speed_thresh  = thresh_ff;

endmodule

// File: hdl/mhb_step.sv
// ----------------------------------------------------------------------------
// Holding-brake step logic
// Brake state and delay / low-speed counters, advanced once per tick.
// ----------------------------------------------------------------------------
module mhb_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  mhb_pkg::tick_type   tick,
   input  mhb_pkg::cfg_type    cfg,
   output mhb_pkg::status_type status
);
   import mhb_pkg::*;

   delay_type         rel_ff, rel_in;
   delay_type         eng_ff, eng_in;
   lsc_type           lsc_ff, lsc_in;
   logic              brake_ff, brake_in;
   delay_type         rel_lim;
   delay_type         eng_lim;
   logic [AbsBits:0]  speed_sum;
   abs_type           speed_mean;
   logic              low_speed;
   lsc_type           lsc_inc;

   // Settings taken to counter width
   assign rel_lim = DelayBits'(cfg.release_delay);
   assign eng_lim = DelayBits'(cfg.engage_delay);

   // Mean of the two absolute velocities against the threshold
   assign speed_sum  = {1'b0, tick.abs_filtered} + {1'b0, tick.abs_feedback};
   assign speed_mean = speed_sum[AbsBits:1];
   assign low_speed  = speed_mean <= AbsBits'(cfg.speed_thresh);
   assign lsc_inc    = lsc_ff + 1'b1;

   // Next state for one tick
   always_comb begin
      rel_in   = rel_ff;
      eng_in   = eng_ff;
      lsc_in   = lsc_ff;
      brake_in = brake_ff;
      if (tick.run_command) begin
         if (rel_ff < rel_lim) begin
            rel_in = rel_ff + 1'b1;
         end else if (tick.drive_ready) begin
            brake_in = 1'b1;
            eng_in   = '0;
            lsc_in   = '0;
         end
      end else begin
         // low-speed run of ticks
         if (low_speed) begin
            if (lsc_inc == LowSpeedTicks) begin
               brake_in = 1'b0;
               rel_in   = '0;
               lsc_in   = '0;
            end else begin
               lsc_in = lsc_inc;
            end
         end else begin
            lsc_in = '0;
         end
         // forced engage after the stop delay
         if (eng_ff < eng_lim) begin
            eng_in = eng_ff + 1'b1;
         end else begin
            brake_in = 1'b0;
            rel_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff   <= '0;
         eng_ff   <= '0;
         lsc_ff   <= '0;
         brake_ff <= 1'b0;
      end else if (advance) begin
         rel_ff   <= rel_in;
         eng_ff   <= eng_in;
         lsc_ff   <= lsc_in;
         brake_ff <= brake_in;
      end
   end

   assign status.brake_open      = brake_ff;
   assign status.low_speed_count = lsc_ff;

endmodule

// File: tb/sv/tb_motor_holding_brake_control_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Holding-brake control unit testbench
// Feeds control ticks through the request channel in random bursts, tracks
// the brake state with a cycle-free model of the counters and compares every
// brake_released result, in order, against that model. Settings are changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_motor_holding_brake_control_unit;
   import mhb_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int LongHold   = 60;

   typedef struct packed {
      logic    run_command;
      logic    drive_ready;
      vel_type speed_filtered;
      vel_type speed_feedback;
   } ctl_tick_type;

   logic clock = 1'b0;
   logic reset;

   mhb_req_if req_if ();
   mhb_rsp_if rsp_if ();
   mhb_csr_if csr_if ();

   motor_holding_brake_control_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Ticks waiting to be sent and brake states waiting to come back
   ctl_tick_type tick_queue[$];
   logic      brake_expected[$];
   int        mismatch_count = 0;
   int        cycle_count    = 0;

   // Model copy of settings and state
   cfg_data_type release_setting;
   cfg_data_type engage_setting;
   cfg_data_type stop_setting;
   delay_type    release_cnt;
   delay_type    engage_cnt;
   lsc_type      low_speed_cnt;
   logic         brake_open;

   // Sender and receiver pacing
   logic        steady_send = 1'b0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen   = 1'b0;
   int          hold_left   = 0;
   int          burst_left  = 1;
   int          gap_left    = 0;
   logic [15:0] stall_pat   = 16'hffff;
   logic [3:0]  pat_pos     = 4'd0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Absolute velocity, most negative value clamps to the largest positive
   function automatic logic [31:0] abs_speed(input vel_type v);
      if (v == 32'sh8000_0000) begin
         return 32'h7fff_ffff;
      end else if (v < 0) begin
         return 32'(-v);
      end
      return 32'(v);
   endfunction

   // Advance the brake model by one tick and return the new brake state
   function automatic logic predict_brake(input ctl_tick_type t);
      logic [32:0] speed_sum;
      logic [31:0] speed_mean;
      logic [47:0] threshold;
      if (t.run_command) begin
         if (release_cnt < delay_type'(release_setting)) begin
            release_cnt = release_cnt + 1'b1;
         end else if (t.drive_ready) begin
            brake_open    = 1'b1;
            engage_cnt    = '0;
            low_speed_cnt = '0;
         end
      end else begin
         speed_sum  = {1'b0, abs_speed(t.speed_filtered)} +
                      {1'b0, abs_speed(t.speed_feedback)};
         speed_mean = speed_sum[32:1];
         threshold  = 48'(stop_setting) * 48'(SpeedScale);
         if (48'(speed_mean) <= threshold) begin
            low_speed_cnt = low_speed_cnt + 1'b1;
            if (low_speed_cnt >= LowSpeedTicks) begin
               brake_open    = 1'b0;
               release_cnt   = '0;
               low_speed_cnt = '0;
            end
         end else begin
            low_speed_cnt = '0;
         end
         if (engage_cnt < delay_type'(engage_setting)) begin
            engage_cnt = engage_cnt + 1'b1;
         end else begin
            brake_open  = 1'b0;
            release_cnt = '0;
         end
      end
      return brake_open;
   endfunction

   // Sender: bursts of items with random gaps, no gaps while steady_send
   always @(posedge clock) begin
      ctl_tick_type nxt;
      if (reset) begin
         req_if.valid          <= 1'b0;
         req_if.run_command    <= 1'b0;
         req_if.drive_ready    <= 1'b0;
         req_if.speed_filtered <= '0;
         req_if.speed_feedback <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0 && !steady_send) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            nxt = tick_queue.pop_front();
            req_if.valid          <= 1'b1;
            req_if.run_command    <= nxt.run_command;
            req_if.drive_ready    <= nxt.drive_ready;
            req_if.speed_filtered <= nxt.speed_filtered;
            req_if.speed_feedback <= nxt.speed_feedback;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = $urandom_range(0, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: long hold on request, otherwise a rotating stall pattern
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= stall_pat[pat_pos];
         pat_pos = pat_pos + 1'b1;
         if (pat_pos == 4'd0) begin
            case ($urandom_range(0, 3))
               0: stall_pat = 16'hffff;
               1: stall_pat = 16'($urandom);
               2: stall_pat = 16'($urandom | $urandom);
               default: stall_pat = 16'($urandom & $urandom);
            endcase
         end
      end
   end

   // Monitor: predict on each accepted tick, check each accepted result
   always @(posedge clock) begin
      ctl_tick_type t;
      logic      want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            t.run_command    = req_if.run_command;
            t.drive_ready    = req_if.drive_ready;
            t.speed_filtered = req_if.speed_filtered;
            t.speed_feedback = req_if.speed_feedback;
            brake_expected.push_back(predict_brake(t));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (brake_expected.size() == 0) begin
               $display("%0t: result with nothing expected, brake_released=%b",
                        $time, rsp_if.brake_released);
               mismatch_count++;
            end else begin
               want = brake_expected.pop_front();
               if (rsp_if.brake_released !== want) begin
                  $display("%0t: brake_released expected %b actual %b",
                           $time, want, rsp_if.brake_released);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Write one setting and mirror it in the model
   task automatic write_reg(input csr_index_type idx, input cfg_data_type value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      case (idx)
         RegReleaseDelay: release_setting = value;
         RegEngageDelay:  engage_setting  = value;
         RegStopSpeed:    stop_setting    = value;
         default: ;
      endcase
   endtask

   task automatic write_settings(input cfg_data_type rel, input cfg_data_type eng,
                                 input cfg_data_type stop);
      write_reg(RegReleaseDelay, rel);
      write_reg(RegEngageDelay, eng);
      write_reg(RegStopSpeed, stop);
   endtask

   task automatic add_tick(input logic run, input logic rdy,
                           input vel_type f, input vel_type b);
      tick_queue.push_back('{run, rdy, f, b});
   endtask

   // Hold until every tick has gone in and every result has come back
   task automatic drain();
      do @(negedge clock);
      while (tick_queue.size() != 0 || req_if.valid || brake_expected.size() != 0);
   endtask

   // Signed velocity of the given magnitude, random sign
   function automatic vel_type signed_speed(input logic [31:0] mag);
      return $urandom_range(0, 1) ? -vel_type'(mag) : vel_type'(mag);
   endfunction

   // Velocity pair: full random, below threshold, around threshold, extremes
   task automatic gen_pair(input int mode, output vel_type f, output vel_type b);
      logic [31:0] thr;
      logic [31:0] total;
      logic [31:0] part;
      vel_type     corner[6];
      corner = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh1,
                 32'sh8000_0001};
      thr = 32'(stop_setting) * SpeedScale;
      case (mode)
         0: begin
            f = vel_type'($urandom);
            b = vel_type'($urandom);
         end
         1: begin
            f = signed_speed($urandom_range(0, thr));
            b = signed_speed($urandom_range(0, thr));
         end
         2: begin
            total = 2 * thr + $urandom_range(0, 3);
            part  = $urandom_range(0, total);
            f = signed_speed(part);
            b = signed_speed(total - part);
         end
         default: begin
            f = corner[$urandom_range(0, 5)];
            b = corner[$urandom_range(0, 5)];
         end
      endcase
   endtask

   // Random ticks: mostly run and stop stretches, some noise
   task automatic gen_random(input int n_items);
      int      count;
      int      kind;
      int      len;
      int      mode;
      logic    low;
      vel_type f;
      vel_type b;
      count = 0;
      while (count < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            len = (release_setting > 20) ? $urandom_range(1, 24)
                                         : $urandom_range(1, release_setting + 4);
            repeat (len) begin
               gen_pair($urandom_range(0, 3), f, b);
               add_tick(1'b1, $urandom_range(0, 4) != 0, f, b);
               count++;
            end
         end else if (kind < 9) begin
            low = $urandom_range(0, 2) != 0;
            len = (engage_setting > 20) ? $urandom_range(1, 24)
                                        : $urandom_range(1, engage_setting + 4);
            repeat (len) begin
               if (low && $urandom_range(0, 7) != 0) begin
                  mode = $urandom_range(1, 2);
               end else begin
                  mode = $urandom_range(0, 3);
               end
               gen_pair(mode, f, b);
               add_tick(1'b0, 1'($urandom), f, b);
               count++;
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               add_tick(1'($urandom), 1'($urandom), vel_type'($urandom),
                        vel_type'($urandom));
               count++;
            end
         end
      end
   endtask

   task automatic run_phase(input cfg_data_type rel, input cfg_data_type eng,
                            input cfg_data_type stop, input int n_items,
                            input logic fill_up);
      write_settings(rel, eng, stop);
      steady_send = fill_up;
      gen_random(n_items);
      // Stall the result side while the sender keeps offering
      if (fill_up) begin
         hold_toggle = ~hold_toggle;
      end
      drain();
      steady_send = 1'b0;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_if.valid          = 1'b0;
      csr_if.index          = RegReleaseDelay;
      csr_if.data           = '0;
      release_setting       = '0;
      engage_setting        = '0;
      stop_setting          = '0;
      release_cnt           = '0;
      engage_cnt            = '0;
      low_speed_cnt         = '0;
      brake_open            = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Release delay with ready low, threshold edges, truncated mean,
      // clamped most negative speed, three low ticks
      write_settings(16'd2, 16'd5, 16'd10);
      add_tick(1'b1, 1'b0, 32'sd0, 32'sd0);
      add_tick(1'b1, 1'b1, 32'sd0, 32'sd0);
      add_tick(1'b1, 1'b0, 32'sd0, 32'sd0);
      add_tick(1'b1, 1'b1, 32'sd0, 32'sd0);
      add_tick(1'b0, 1'b0, 32'sh8000_0000, 32'sh8000_0000);
      add_tick(1'b0, 1'b1, 32'sh7fff_ffff, -32'sd1);
      add_tick(1'b0, 1'b0, 32'sd22000, -32'sd22000);
      add_tick(1'b0, 1'b0, 32'sd22001, 32'sd22001);
      add_tick(1'b0, 1'b0, -32'sd22000, 32'sd22001);
      add_tick(1'b0, 1'b0, 32'sd0, 32'sd0);
      add_tick(1'b0, 1'b1, 32'sd1, -32'sd1);
      drain();

      // Zero delays: act on the first tick, forced engage on every stop tick
      write_settings(16'd0, 16'd0, 16'd0);
      add_tick(1'b1, 1'b1, 32'sd5, 32'sd5);
      add_tick(1'b0, 1'b0, 32'sd1, 32'sd1);
      add_tick(1'b1, 1'b1, 32'sd0, 32'sd0);
      add_tick(1'b0, 1'b0, 32'sd0, 32'sd0);
      add_tick(1'b0, 1'b0, 32'sd0, -32'sd1);
      add_tick(1'b0, 1'b1, 32'sh8000_0000, 32'sd0);
      drain();

      // Largest settings
      write_settings(16'hffff, 16'hffff, 16'hffff);
      add_tick(1'b1, 1'b1, 32'sd0, 32'sd0);
      add_tick(1'b1, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000);
      add_tick(1'b0, 1'b1, 32'sh7fff_ffff, 32'sh7fff_ffff);
      add_tick(1'b0, 1'b0, 32'sd144177000, -32'sd144177000);
      add_tick(1'b0, 1'b0, 32'sd144177001, 32'sd144177001);
      drain();

      run_phase(16'd3, 16'd6, 16'd100, 235, 1'b0);
      run_phase(16'd0, 16'd10, 16'hffff, 235, 1'b0);
      run_phase(16'hffff, 16'd0, 16'd0, 235, 1'b0);
      run_phase(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                16'($urandom_range(0, 3000)), 235, 1'b1);
      run_phase(16'd1, 16'hffff, 16'd5000, 235, 1'b0);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 235, 1'b0);
      run_phase(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                16'($urandom_range(0, 65535)), 235, 1'b0);
      run_phase(16'd0, 16'd0, 16'($urandom_range(0, 50)), 235, 1'b0);

      // Let any stray result show up before the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && brake_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
